>>> hdl/dtf_pkg.sv
// shared constants for the double to fixed-point converter
`timescale 1ns / 1ps
package dtf_pkg;
  localparam int unsigned DblW   = 64;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned FracW  = 52;
  localparam int unsigned MantW  = FracW + 1;
  localparam int unsigned ScaleW = 13;
  localparam int unsigned TotW   = 7;
  localparam int unsigned FbW    = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 7;
  localparam logic [ExpW-1:0] ExpMax = '1;
  localparam logic signed [ScaleW-1:0] ExpBias = 13'sd1075;
  localparam logic signed [ScaleW-1:0] ExpSub  = -13'sd1074;

  typedef enum logic [CfgIdxW-1:0] {
    RegTotalBits  = 2'd0,
    RegFracBits   = 2'd1,
    RegSignedMode = 2'd2
  } cfg_reg_e;
endpackage

>>> hdl/double_to_fixed_converter.sv
// Double to fixed-point converter.
// Input channel: in_valid_i, in_stall_o, float_bits_i (binary64 bit pattern).
// Output channel: out_valid_o, out_stall_i, fixed_value_o, status_o.
// An item moves on an edge where valid is high and stall is low.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 total bits, 1 fractional bits, 2 signed mode. Ready is always high.
// Write configuration only while no item is in flight.
// Four register stages: decode, scaling shift, rounding add, range check and
// sign apply. An accepted item moves through stages 1 to 4 to out_valid_o, and
// one item is accepted every cycle while in_stall_o is low.
// A stalled output holds its item; upstream stages keep filling bubbles,
// and in_stall_o rises only once every stage holds an item.
// status_o is 1 for NaN, infinity or a value outside the format range, and
// then fixed_value_o is zero. Signed results are sign-extended to 64 bits.
// Reset clears all valid bits and loads total 16, fractional 8, signed mode.
`timescale 1ns / 1ps
module double_to_fixed_converter import dtf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [DblW-1:0]    float_bits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DblW-1:0]    fixed_value_o,
  output logic               status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);
  logic [TotW-1:0] total_q;
  logic [FbW-1:0]  frac_q;
  logic            smode_q;
  logic [TotW-1:0] tnorm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 7'd16;
      frac_q  <= 6'd8;
      smode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegTotalBits:  total_q <= cfg_data_i;
        RegFracBits:   frac_q  <= cfg_data_i[FbW-1:0];
        RegSignedMode: smode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tnorm = total_q;
    if (total_q == '0) tnorm = 7'd1;
    if (total_q > 7'd64) tnorm = 7'd64;
  end

  // stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: decode
  logic                     s1_neg_q, s1_nan_q, s1_zero_q;
  logic signed [ScaleW-1:0] s1_e_q;
  logic [MantW-1:0]         s1_mant_q;
  logic [ExpW-1:0]          bexp;
  logic signed [ScaleW-1:0] e_d;

  assign bexp = float_bits_i[DblW-2 -: ExpW];
  always_comb begin
    if (bexp != '0) e_d = $signed({2'b00, bexp}) - ExpBias;
    else            e_d = ExpSub;
    e_d = e_d + $signed({7'd0, frac_q});
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_neg_q  <= float_bits_i[DblW-1];
      s1_nan_q  <= (bexp == ExpMax);
      s1_zero_q <= (float_bits_i[FracW-1:0] == '0) && (bexp == '0);
      s1_mant_q <= {(bexp != '0), float_bits_i[FracW-1:0]};
      s1_e_q    <= e_d;
    end
  end

  // stage 2: scaling shift
  logic                     s2_neg_q, s2_err_q, s2_rnd_q;
  logic [DblW-1:0]          s2_val_q;
  logic                     err2_d, rnd2_d;
  logic [DblW-1:0]          val2_d;
  logic [2*DblW-1:0]        wide;
  logic signed [ScaleW-1:0] sh;
  logic [MantW-1:0]         rsh;

  always_comb begin
    err2_d = 1'b0;
    rnd2_d = 1'b0;
    val2_d = '0;
    wide   = '0;
    sh     = -s1_e_q;
    rsh    = '0;
    if (s1_nan_q) begin
      err2_d = 1'b1;
    end else if (s1_zero_q) begin
      val2_d = '0;
    end else if (s1_e_q >= 0) begin
      if (s1_e_q >= 13'sd64) begin
        err2_d = 1'b1;
      end else begin
        wide   = {{(2*DblW-MantW){1'b0}}, s1_mant_q} << s1_e_q[5:0];
        err2_d = |wide[2*DblW-1:DblW];
        val2_d = wide[DblW-1:0];
      end
    end else if (sh < 13'sd54) begin
      rsh    = s1_mant_q >> (sh[5:0] - 6'd1);
      val2_d = {{(DblW-MantW){1'b0}}, rsh >> 1};
      rnd2_d = rsh[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_neg_q <= s1_neg_q;
      s2_err_q <= err2_d;
      s2_val_q <= val2_d;
      s2_rnd_q <= rnd2_d;
    end
  end

  // stage 3: round half away from zero
  logic            s3_neg_q, s3_err_q;
  logic [DblW-1:0] s3_mag_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_neg_q <= s2_neg_q;
      s3_err_q <= s2_err_q;
      s3_mag_q <= s2_val_q + {{(DblW-1){1'b0}}, s2_rnd_q};
    end
  end

  // stage 4: range check and sign
  logic [DblW-1:0] lim, out_q;
  logic            err4, st_q;

  always_comb begin
    lim  = '0;
    err4 = s3_err_q;
    if (smode_q) begin
      lim = 64'd1 << (tnorm - 7'd1);
      if (s3_neg_q ? (s3_mag_q > lim) : (s3_mag_q >= lim)) err4 = 1'b1;
    end else begin
      if (s3_neg_q) begin
        if (s3_mag_q != '0) err4 = 1'b1;
      end else if (tnorm != 7'd64) begin
        lim = 64'd1 << tnorm[5:0];
        if (s3_mag_q >= lim) err4 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      st_q  <= err4;
      out_q <= err4 ? '0 : (s3_neg_q ? (64'd0 - s3_mag_q) : s3_mag_q);
    end
  end

  assign out_valid_o   = v4_q;
  assign fixed_value_o = out_q;
  assign status_o      = st_q;
endmodule

>>> hdl/dtf_checker.sv
// port-level checks for the double to fixed-point converter
`timescale 1ns / 1ps
module dtf_checker import dtf_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [DblW-1:0] fixed_value_o,
  input logic            status_o
);
  // an error item carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> fixed_value_o == '0)
    else $error("error item with nonzero value");

  // with no item waiting at the output the input never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fixed_value_o)
      && $stable(status_o))
    else $error("stalled item changed");

  // pipeline is empty right after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("valid after reset");
endmodule

bind double_to_fixed_converter dtf_checker u_dtf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .fixed_value_o (fixed_value_o),
  .status_o      (status_o)
);
